/* rtl/pwmdw_pkg.sv */
// Shared constants and types for the PWM divider, wrap and compare-level calculator.
package pwmdw_pkg;

	localparam int unsigned SRC_CLOCK_HZ = 125000000;
	localparam int unsigned WRAP_STEPS   = 4096;
	localparam int unsigned FRAC_ONE     = 16;
	localparam int unsigned DUTY_FULL    = 100;
	localparam int unsigned FREQ_MIN     = 8;

	localparam int unsigned SLICE_W = 3;
	localparam int unsigned FREQ_W  = 26;
	localparam int unsigned DUTY_W  = 7;

	// first divide: ceil(clock / (f * 4096)) as floor((clock / 4096) / f) plus a round-up
	localparam int unsigned SPAN_BASE    = SRC_CLOCK_HZ / WRAP_STEPS;
	localparam logic        SPAN_LOW_REM = (SRC_CLOCK_HZ % WRAP_STEPS) != 0;
	localparam int unsigned R1_W         = 15;
	localparam int unsigned Q1_W         = 12;

	// second divide: (clock * 16) / (divider16 * f)
	localparam int unsigned TICKS16 = SRC_CLOCK_HZ * FRAC_ONE;
	localparam int unsigned R2_W    = 31;
	localparam int unsigned Q2_W    = 17;

	// divide by 100 through a reciprocal, exact for products below 2**23
	localparam int unsigned X_W          = 23;
	localparam int unsigned RECIP_SHIFT  = 30;
	localparam int unsigned RECIP        = ((1 << RECIP_SHIFT) + DUTY_FULL - 1) / DUTY_FULL;
	localparam int unsigned RECIP_W      = 24;
	localparam int unsigned Y_W          = X_W + RECIP_W;

	typedef struct packed {
		logic [SLICE_W-1:0] slice;
		logic               chan;
		logic [DUTY_W-1:0]  duty;
		logic [FREQ_W-1:0]  freq;
	} ctx_t;

	typedef struct packed {
		ctx_t             ctx;
		logic [Q1_W-1:0]  div16;
	} ctx2_t;

endpackage

/* rtl/pwm_divider_wrap_level_calc.sv */
// PWM divider, wrap and compare-level calculator: one deep pipeline.
// Throughput: one item per cycle while no valid output is stalled; the 12-stage
// and 17-stage restoring dividers retire one quotient bit per stage, so nothing
// iterates in place. A stalled valid output holds the whole pipeline; in_stall
// follows at once. Reset (arst_n low) clears every valid bit; payload registers
// are not reset.
module pwm_divider_wrap_level_calc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  slice_index,
	input  logic        channel_index,
	input  logic [25:0] freq_hz,
	input  logic [6:0]  duty_percent,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  out_slice,
	output logic        out_channel,
	output logic [7:0]  div_integer,
	output logic [3:0]  div_fraction,
	output logic [15:0] wrap_value,
	output logic [15:0] compare_level
);

	localparam int FW  = pwmdw_pkg::FREQ_W;
	localparam int DW  = pwmdw_pkg::DUTY_W;
	localparam int R1W = pwmdw_pkg::R1_W;
	localparam int Q1W = pwmdw_pkg::Q1_W;
	localparam int R2W = pwmdw_pkg::R2_W;
	localparam int Q2W = pwmdw_pkg::Q2_W;
	localparam int XW  = pwmdw_pkg::X_W;
	localparam int RW  = pwmdw_pkg::RECIP_W;
	localparam int YW  = pwmdw_pkg::Y_W;
	localparam int PW  = Q1W + FW;

	// Advance every stage together unless a finished item waits on a stalled output.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Input stage: clamp frequency from below, saturate duty.
	pwmdw_pkg::ctx_t in_ctx;
	always_comb begin
		in_ctx.slice = slice_index;
		in_ctx.chan  = channel_index;
		in_ctx.freq  = (freq_hz < FW'(pwmdw_pkg::FREQ_MIN)) ? FW'(pwmdw_pkg::FREQ_MIN) : freq_hz;
		in_ctx.duty  = (duty_percent > DW'(pwmdw_pkg::DUTY_FULL)) ?
			DW'(pwmdw_pkg::DUTY_FULL) : duty_percent;
	end

	// First divider: index 0 is the input stage (s1), then one quotient bit per stage.
	logic [Q1W:0]    d1_v;
	pwmdw_pkg::ctx_t d1_ctx [0:Q1W];
	logic [R1W-1:0]  d1_rem [0:Q1W];
	logic [Q1W-1:0]  d1_quo [0:Q1W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_v[0] <= 1'b0;
		end else if (adv) begin
			d1_v[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_ctx[0] <= in_ctx;
			d1_rem[0] <= R1W'(pwmdw_pkg::SPAN_BASE);
			d1_quo[0] <= '0;
		end
	end

	for (genvar k = 0; k < Q1W; k++) begin : g_div1
		localparam int B = Q1W - 1 - k;
		logic [R1W-1:0] shr;
		logic           take;
		always_comb begin
			shr  = d1_rem[k] >> B;
			take = FW'(shr) >= d1_ctx[k].freq;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d1_v[k+1] <= 1'b0;
			end else if (adv) begin
				d1_v[k+1] <= d1_v[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				d1_ctx[k+1] <= d1_ctx[k];
				d1_rem[k+1] <= take ? (d1_rem[k] - R1W'(d1_ctx[k].freq << B)) : d1_rem[k];
				d1_quo[k+1] <= {d1_quo[k][Q1W-2:0], take};
			end
		end
	end

	// Round the divider up, force divide-by-one when its integer part is zero.
	logic [Q1W-1:0] div16_c;
	always_comb begin
		div16_c = d1_quo[Q1W] +
			Q1W'(pwmdw_pkg::SPAN_LOW_REM || (d1_rem[Q1W] != '0));
		if (div16_c[Q1W-1:4] == '0) begin
			div16_c = Q1W'(pwmdw_pkg::FRAC_ONE);
		end
	end

	logic            valid_s2;
	pwmdw_pkg::ctx_t ctx_s2;
	logic [Q1W-1:0]  div16_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= d1_v[Q1W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s2   <= d1_ctx[Q1W];
			div16_s2 <= div16_c;
		end
	end

	// Second divider: index 0 holds the divisor product (s3).
	logic [PW-1:0] prod_c;
	assign prod_c = PW'(div16_s2) * PW'(ctx_s2.freq);

	logic [Q2W:0]     d2_v;
	pwmdw_pkg::ctx2_t d2_ctx [0:Q2W];
	logic [R2W-1:0]   d2_div [0:Q2W];
	logic [R2W-1:0]   d2_rem [0:Q2W];
	logic [Q2W-1:0]   d2_quo [0:Q2W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d2_v[0] <= 1'b0;
		end else if (adv) begin
			d2_v[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d2_ctx[0].ctx   <= ctx_s2;
			d2_ctx[0].div16 <= div16_s2;
			d2_div[0]       <= prod_c[R2W-1:0];
			d2_rem[0]       <= R2W'(pwmdw_pkg::TICKS16);
			d2_quo[0]       <= '0;
		end
	end

	for (genvar k = 0; k < Q2W; k++) begin : g_div2
		localparam int B = Q2W - 1 - k;
		logic [R2W-1:0] shr;
		logic           take;
		always_comb begin
			shr  = d2_rem[k] >> B;
			take = shr >= d2_div[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d2_v[k+1] <= 1'b0;
			end else if (adv) begin
				d2_v[k+1] <= d2_v[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				d2_ctx[k+1] <= d2_ctx[k];
				d2_div[k+1] <= d2_div[k];
				d2_rem[k+1] <= take ? (d2_rem[k] - (d2_div[k] << B)) : d2_rem[k];
				d2_quo[k+1] <= {d2_quo[k][Q2W-2:0], take};
			end
		end
	end

	// Wrap is the period minus one; form wrap times duty for the level.
	logic [Q2W-1:0] per_m1_c;
	logic [15:0]    wrap_c;
	assign per_m1_c = d2_quo[Q2W] - Q2W'(1);
	assign wrap_c   = per_m1_c[15:0];

	logic             valid_s4;
	pwmdw_pkg::ctx2_t ctx_s4;
	logic [15:0]      wrap_s4;
	logic [XW-1:0]    x_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= d2_v[Q2W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s4  <= d2_ctx[Q2W];
			wrap_s4 <= wrap_c;
			x_s4    <= XW'(wrap_c) * XW'(d2_ctx[Q2W].ctx.duty);
		end
	end

	// Divide by one hundred through the reciprocal, then drive the output register.
	logic [YW-1:0] y_c;
	assign y_c = YW'(x_s4) * YW'(RW'(pwmdw_pkg::RECIP));

	logic        out_valid_q;
	logic [2:0]  out_slice_q;
	logic        out_channel_q;
	logic [7:0]  div_integer_q;
	logic [3:0]  div_fraction_q;
	logic [15:0] wrap_value_q;
	logic [15:0] compare_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_slice_q     <= ctx_s4.ctx.slice;
			out_channel_q   <= ctx_s4.ctx.chan;
			div_integer_q   <= ctx_s4.div16[11:4];
			div_fraction_q  <= ctx_s4.div16[3:0];
			wrap_value_q    <= wrap_s4;
			compare_level_q <= y_c[pwmdw_pkg::RECIP_SHIFT +: 16];
		end
	end

	assign out_valid     = out_valid_q;
	assign out_slice     = out_slice_q;
	assign out_channel   = out_channel_q;
	assign div_integer   = div_integer_q;
	assign div_fraction  = div_fraction_q;
	assign wrap_value    = wrap_value_q;
	assign compare_level = compare_level_q;

`ifndef ASSERT_OFF
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> div_integer != 8'd0)
		else $error("integer divider is zero");

	a_level_le_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> compare_level <= wrap_value)
		else $error("compare level above wrap");

	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		d2_v[Q2W] |-> d2_quo[Q2W] != '0)
		else $error("period quotient is zero");
`endif

endmodule

/* tb/tb_top.sv */
// Testbench for the PWM divider, wrap and compare-level calculator.
`timescale 1ns / 100ps

module tb_top;

	// Pipeline depth from an accepted item to its result.
	localparam int PIPE_LATENCY = 34;

	typedef struct packed {
		logic [2:0]  slice;
		logic        chan;
		logic [7:0]  div_int;
		logic [3:0]  div_frac;
		logic [15:0] wrap;
		logic [15:0] level;
	} pwm_setting_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  slice_index = '0;
	logic        channel_index = 1'b0;
	logic [25:0] freq_hz = 26'd1000;
	logic [6:0]  duty_percent = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  out_slice;
	logic        out_channel;
	logic [7:0]  div_integer;
	logic [3:0]  div_fraction;
	logic [15:0] wrap_value;
	logic [15:0] compare_level;

	pwm_setting_t expected_settings[$];
	int           mismatch_count = 0;
	bit           idle_enable = 1'b1;

	pwm_divider_wrap_level_calc u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.slice_index(slice_index), .channel_index(channel_index),
		.freq_hz(freq_hz), .duty_percent(duty_percent),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_slice(out_slice), .out_channel(out_channel),
		.div_integer(div_integer), .div_fraction(div_fraction),
		.wrap_value(wrap_value), .compare_level(compare_level)
	);

	always #5 clk = ~clk;

	// Compute the PWM setting for one request at 64-bit width.
	function automatic pwm_setting_t calc_pwm_setting(logic [2:0] slice, logic chan,
			logic [25:0] freq_in, logic [6:0] duty_in);
		longint unsigned freq, duty, span, div16, wrap;
		pwm_setting_t s;
		freq = 64'(freq_in);
		duty = 64'(duty_in);
		// saturate frequency below range and duty above full scale
		if (freq < 8) freq = 8;
		if (duty > 100) duty = 100;
		span = freq * 64'd4096;
		div16 = 64'd125000000 / freq / 64'd4096;
		if ((64'd125000000 % span) != 0) div16 += 1;
		// never divide by less than one
		if (div16 / 16 == 0) div16 = 16;
		wrap = (64'd125000000 * 16 / div16 / freq - 1) & 64'hFFFF;
		s.slice    = slice;
		s.chan     = chan;
		s.div_int  = 8'((div16 / 16) & 64'hFF);
		s.div_frac = 4'(div16 & 64'hF);
		s.wrap     = 16'(wrap);
		s.level    = 16'((wrap * duty / 100) & 64'hFFFF);
		return s;
	endfunction

	// Present one request, hold it until accepted, then queue its prediction.
	task automatic send_request(logic [2:0] slice, logic chan, logic [25:0] freq,
			logic [6:0] duty);
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		slice_index   <= slice;
		channel_index <= chan;
		freq_hz       <= freq;
		duty_percent  <= duty;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_settings.push_back(calc_pwm_setting(slice, chan, freq, duty));
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_settings.size() != 0) @(posedge clk);
	endtask

	// Random request with a frequency spread over decades so both small
	// and large dividers show up, plus raw 26-bit noise now and then.
	task automatic send_random_request();
		logic [25:0] freq;
		int decade;
		decade = $urandom_range(0, 9);
		case (decade)
			0: freq = 26'($urandom_range(0, 7));
			1: freq = 26'($urandom_range(8, 100));
			2: freq = 26'($urandom_range(100, 2000));
			3: freq = 26'($urandom_range(2000, 40000));
			4: freq = 26'($urandom_range(40000, 1000000));
			5: freq = 26'($urandom_range(1000000, 62500000));
			6: freq = 26'($urandom);
			default: freq = 26'($urandom_range(8, 62500000));
		endcase
		send_request(3'($urandom), 1'($urandom), freq, 7'($urandom));
	endtask

	// Extremes of every field and each saturation case.
	task automatic test_directed();
		send_request(3'd0, 1'b0, 26'd0, 7'd0);
		send_request(3'd7, 1'b1, 26'd7, 7'd127);
		send_request(3'd1, 1'b0, 26'd8, 7'd100);
		send_request(3'd2, 1'b1, 26'd9, 7'd101);
		send_request(3'd3, 1'b0, 26'd1000, 7'd50);
		send_request(3'd4, 1'b1, 26'd1907, 7'd1);
		send_request(3'd5, 1'b0, 26'd1908, 7'd99);
		send_request(3'd6, 1'b1, 26'd30517, 7'd33);
		send_request(3'd7, 1'b0, 26'd30518, 7'd66);
		send_request(3'd0, 1'b1, 26'd62500000, 7'd100);
		send_request(3'd1, 1'b0, 26'd62500001, 7'd75);
		send_request(3'd2, 1'b1, 26'h3FFFFFF, 7'd127);
		send_request(3'd5, 1'b0, 26'h2AAAAAA, 7'h55);
		send_request(3'd2, 1'b1, 26'h1555555, 7'h2A);
		send_request(3'd3, 1'b0, 26'd125, 7'd100);
		send_request(3'd4, 1'b1, 26'd50000, 7'd25);
		drop_valid();
		wait_drained();
	endtask

	// Random stream with bursts of idling on both sides.
	task automatic test_random_idling();
		repeat (600) send_random_request();
		drop_valid();
		// hold off until the pipeline has emptied, then resume
		wait_drained();
		repeat (150) send_random_request();
		drop_valid();
	endtask

	// Back-to-back stream with no idling at all.
	task automatic test_full_rate();
		idle_enable = 1'b0;
		repeat (200) send_random_request();
		drop_valid();
	endtask

	// Receiver stall bursts; quiet once the full-rate phase begins.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_enable && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 9);
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	// Check each accepted result against the oldest prediction.
	always @(posedge clk) begin
		pwm_setting_t exp_s, got_s;
		if (arst_n && out_valid && !out_stall) begin
			got_s = '{out_slice, out_channel, div_integer, div_fraction,
				wrap_value, compare_level};
			if (expected_settings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: %p", got_s);
			end else begin
				exp_s = expected_settings.pop_front();
				if (got_s !== exp_s) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p actual %p", exp_s, got_s);
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_idling();
		test_full_rate();
		wait_drained();
		repeat (PIPE_LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0 && expected_settings.size() == 0)
			$display("pwm_divider_wrap_level_calc verification clean");
		else
			$display("pwm_divider_wrap_level_calc verification failed");
		$finish;
	end

	// Timeout guard.
	initial begin
		#2ms;
		$display("pwm_divider_wrap_level_calc verification failed");
		$finish;
	end

endmodule
